// File: design/ivd_pkg.sv
`default_nettype none

package ivd_pkg;

  // metric register codes
  typedef enum logic [1:0] {
    METRIC_L2  = 2'd0,
    METRIC_IP  = 2'd1,
    METRIC_COS = 2'd2
  } metric_e;

  // accumulator and result widths
  localparam int unsigned ElemW  = 8;
  localparam int unsigned SqW    = 28;
  localparam int unsigned DotW   = 28;
  localparam int unsigned NormW  = 27;
  localparam int unsigned SumW   = 29;
  localparam int unsigned CosW   = 16;
  localparam int unsigned ProdW  = 2 * NormW;
  localparam int unsigned RootW  = NormW;
  localparam int unsigned FracW  = 15;
  localparam int unsigned QuoW   = DotW + FracW;
  localparam int unsigned StepW  = $clog2(QuoW + 1);

  // last iteration indices of the sequential units
  localparam logic [StepW-1:0] SqrtLast = StepW'(RootW - 1);
  localparam logic [StepW-1:0] DivLast  = StepW'(QuoW - 1);

  // q1.15 saturation bounds
  localparam logic [QuoW-1:0] CosPosLimit = QuoW'(32767);
  localparam logic [QuoW-1:0] CosNegLimit = QuoW'(32768);
  localparam logic [CosW-1:0] CosMax      = 16'h7fff;
  localparam logic [CosW-1:0] CosMin      = 16'h8000;

  // job queue depth
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // one finished vector handed from front to back
  typedef struct packed {
    logic [SqW-1:0]          sqdiff;
    logic signed [DotW-1:0]  dot;
    logic [NormW-1:0]        norm_a;
    logic [NormW-1:0]        norm_b;
    logic                    too_long;
    metric_e                 metric;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SQRT,
    BK_DIV,
    BK_OUT
  } back_state_e;

endpackage

`default_nettype wire

// File: design/int8_vector_distance.sv
// int8 vector distance: one element pair per cycle, one result per vector.
// l2 and inner product results pass through the job queue, the back part's job register
// and the output register; cosine results go through job pickup, one 27x27 multiply,
// 27 square-root steps, 43 division steps and the output load; a two-job queue lets input
// continue meanwhile and stalls it only while two finished vectors wait. asynchronous
// active-low reset clears sums, counters, the queue and the metric register (l2).
`default_nettype none

module int8_vector_distance import ivd_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config: metric
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // elem_a [7:0], elem_b [15:8]
  input  wire logic        s_axis_tlast_i,
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // sum_value [28:0], cosine_q15 [44:29], zero pad
  output logic             m_axis_tuser_o    // too_long [0]
);

  metric_e         metric_q;
  logic            push, full, pop, job_valid;
  job_t            front_job, queue_job;
  logic [SumW-1:0] sum_value;
  logic [CosW-1:0] cosine_q15;

  // metric register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= METRIC_L2;
    end else if (cfg_we_i) begin
      metric_q <= metric_e'(cfg_wdata_i);
    end
  end

  ivd_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .elem_a_i   (s_axis_tdata_i[7:0]),
    .elem_b_i   (s_axis_tdata_i[15:8]),
    .last_i     (s_axis_tlast_i),
    .metric_i   (metric_q),
    .full_i     (full),
    .push_o     (push),
    .job_o      (front_job)
  );

  ivd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (queue_job)
  );

  ivd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (queue_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sum_o       (sum_value),
    .cos_o       (cosine_q15),
    .too_long_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {3'b000, cosine_q15, sum_value};

endmodule

`default_nettype wire

// File: design/ivd_front.sv
`default_nettype none

module ivd_front import ivd_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [ElemW-1:0] elem_a_i,
  input  wire logic signed [ElemW-1:0] elem_b_i,
  input  wire logic                    last_i,
  input  wire metric_e                 metric_i,
  input  wire logic                    full_i,
  output logic                         push_o,
  output job_t                         job_o
);

  localparam int unsigned CntW = $clog2(MAX_DIM + 1);

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [SqW-1:0]         sq_q, sq_d, sq_new;
  logic signed [DotW-1:0] dot_q, dot_d, dot_new;
  logic [NormW-1:0]       na_q, na_d, na_new;
  logic [NormW-1:0]       nb_q, nb_d, nb_new;
  logic                   ovf_q, ovf_d;

  logic                   accept;
  logic                   room;
  logic signed [8:0]      diff;
  logic signed [17:0]     dsq;
  logic signed [15:0]     pab, paa, pbb;
  logic [SqW:0]           sq_sum;
  logic signed [DotW:0]   dot_sum;
  logic [NormW:0]         na_sum, nb_sum;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && last_i;
  assign room       = cnt_q < CntW'(MAX_DIM);

  // element products, exact 9-bit difference
  always_comb begin
    diff = 9'(elem_a_i) - 9'(elem_b_i);
    dsq  = diff * diff;
    pab  = elem_a_i * elem_b_i;
    paa  = elem_a_i * elem_a_i;
    pbb  = elem_b_i * elem_b_i;
  end

  // saturating accumulate
  always_comb begin
    sq_sum  = {1'b0, sq_q} + (SqW + 1)'(dsq[16:0]);
    sq_new  = sq_sum[SqW] ? '1 : sq_sum[SqW-1:0];
    dot_sum = (DotW + 1)'(dot_q) + (DotW + 1)'(pab);
    if (dot_sum[DotW] != dot_sum[DotW-1]) begin
      dot_new = dot_sum[DotW] ? {1'b1, {(DotW - 1){1'b0}}} : {1'b0, {(DotW - 1){1'b1}}};
    end else begin
      dot_new = dot_sum[DotW-1:0];
    end
    na_sum  = {1'b0, na_q} + (NormW + 1)'(paa[14:0]);
    na_new  = na_sum[NormW] ? '1 : na_sum[NormW-1:0];
    nb_sum  = {1'b0, nb_q} + (NormW + 1)'(pbb[14:0]);
    nb_new  = nb_sum[NormW] ? '1 : nb_sum[NormW-1:0];
  end

  // job for the back part, includes the closing element unless the dimension limit is reached
  always_comb begin
    job_o.sqdiff   = room ? sq_new  : sq_q;
    job_o.dot      = room ? dot_new : dot_q;
    job_o.norm_a   = room ? na_new  : na_q;
    job_o.norm_b   = room ? nb_new  : nb_q;
    job_o.too_long = ovf_q || !room;
    job_o.metric   = metric_i;
  end

  // next accumulator state
  always_comb begin
    cnt_d = cnt_q;
    sq_d  = sq_q;
    dot_d = dot_q;
    na_d  = na_q;
    nb_d  = nb_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (last_i) begin
        cnt_d = '0;
        sq_d  = '0;
        dot_d = '0;
        na_d  = '0;
        nb_d  = '0;
        ovf_d = 1'b0;
      end else if (room) begin
        cnt_d = cnt_q + 1'b1;
        sq_d  = sq_new;
        dot_d = dot_new;
        na_d  = na_new;
        nb_d  = nb_new;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sq_q  <= '0;
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sq_q  <= sq_d;
      dot_q <= dot_d;
      na_q  <= na_d;
      nb_q  <= nb_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// File: design/ivd_queue.sv
`default_nettype none

module ivd_queue import ivd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign full_o  = count_q == (QPtrW + 1)'(QDepth);
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// File: design/ivd_back.sv
`default_nettype none

module ivd_back import ivd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [SumW-1:0] sum_o,
  output logic [CosW-1:0] cos_o,
  output logic      too_long_o
);

  back_state_e      state_q, state_d;
  job_t             job_q;
  logic [ProdW-1:0] prod_q;
  logic [RootW:0]   rem_q;
  logic [RootW-1:0] root_q;
  logic [QuoW-1:0]  quo_q;
  logic [StepW-1:0] cnt_q;
  logic             out_valid_q;
  logic [SumW-1:0]  sum_q;
  logic [CosW-1:0]  cos_q;
  logic             too_long_q;

  logic             load_out;
  logic             norms_zero;
  logic             cos_mode;
  logic [RootW+2:0] sq_rem_next, sq_trial;
  logic             sq_take;
  logic [RootW:0]   dv_rem_next;
  logic             dv_take;
  logic [DotW-1:0]  dot_mag;
  logic [SumW-1:0]  sum_sel;
  logic [CosW-1:0]  cos_sel;

  assign norms_zero = (job_q.norm_a == '0) || (job_q.norm_b == '0);
  assign cos_mode   = job_q.metric == METRIC_COS;
  assign dot_mag    = job_q.dot[DotW-1] ? DotW'(-job_q.dot) : DotW'(job_q.dot);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          if (job_i.metric == METRIC_COS && job_i.norm_a != '0 && job_i.norm_b != '0) begin
            state_d = BK_MUL;
          end else begin
            state_d = BK_OUT;
          end
        end
      end
      BK_MUL:  state_d = BK_SQRT;
      BK_SQRT: begin
        if (cnt_q == SqrtLast) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_q == DivLast) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: pop_o    = job_valid_i;
      BK_OUT:  load_out = !out_valid_q || out_ready_i;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // one root bit per cycle, two radicand bits per step
  always_comb begin
    sq_rem_next = {rem_q, prod_q[ProdW-1 -: 2]};
    sq_trial    = (RootW + 3)'({root_q, 2'b01});
    sq_take     = sq_rem_next >= sq_trial;
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    dv_rem_next = {rem_q[RootW-1:0], quo_q[QuoW-1]};
    dv_take     = dv_rem_next >= {1'b0, root_q};
  end

  // result selection and q1.15 saturation
  always_comb begin
    case (job_q.metric)
      METRIC_L2: sum_sel = {1'b0, job_q.sqdiff};
      METRIC_IP: sum_sel = SumW'(job_q.dot);
      default:   sum_sel = '0;
    endcase
    if (!cos_mode || norms_zero) begin
      cos_sel = '0;
    end else if (job_q.dot[DotW-1]) begin
      cos_sel = (quo_q > CosNegLimit) ? CosMin : CosW'(-quo_q[CosW-1:0]);
    end else begin
      cos_sel = (quo_q > CosPosLimit) ? CosMax : quo_q[CosW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          job_q <= job_i;
        end
      end
      BK_MUL: begin
        prod_q <= ProdW'(job_q.norm_a) * ProdW'(job_q.norm_b);
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end
      BK_SQRT: begin
        prod_q <= {prod_q[ProdW-3:0], 2'b00};
        root_q <= {root_q[RootW-2:0], sq_take};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == SqrtLast) begin
          rem_q <= '0;
          quo_q <= {dot_mag, {FracW{1'b0}}};
          cnt_q <= '0;
        end else begin
          rem_q <= sq_take ? (RootW + 1)'(sq_rem_next - sq_trial) : (RootW + 1)'(sq_rem_next);
        end
      end
      BK_DIV: begin
        quo_q <= {quo_q[QuoW-2:0], dv_take};
        rem_q <= dv_take ? dv_rem_next - {1'b0, root_q} : dv_rem_next;
        cnt_q <= cnt_q + 1'b1;
      end
      BK_OUT: begin
        if (load_out) begin
          sum_q      <= sum_sel;
          cos_q      <= cos_sel;
          too_long_q <= job_q.too_long;
        end
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign sum_o       = sum_q;
  assign cos_o       = cos_q;
  assign too_long_o  = too_long_q;

endmodule

`default_nettype wire

// File: design/ivd_checker.sv
`default_nettype none

module ivd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o
);

  // no result is offered in the cycle after reset is seen
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid after reset");

  // a stalled result transaction keeps its content
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // sum and cosine fields are never both in use
  a_one_metric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[28:0] == 29'd0) || (m_axis_tdata_o[44:29] == 16'd0))
    else $error("sum and cosine both nonzero");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[47:45] == 3'd0)
    else $error("pad bits set");

endmodule

bind int8_vector_distance ivd_checker u_ivd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
